// ===== rtl/core/rcfr_pkg.sv =====
`timescale 1ns / 1ps

package rcfr_pkg;

  localparam int unsigned MaxChannels = 256;
  localparam int unsigned MaxResBits  = 12;
  localparam int unsigned IdxW        = $clog2(MaxChannels);
  localparam int unsigned CntW        = IdxW + 1;
  localparam int unsigned ValW        = MaxResBits;

  localparam logic [7:0] StartMark = 8'hC9;
  localparam logic [7:0] EndMark   = 8'h93;

  localparam logic OpRxByte   = 1'b0;
  localparam logic OpReadChan = 1'b1;

  typedef struct packed {
    logic       opcode;
    logic [7:0] data_byte;
    logic [7:0] channel_index;
  } in_t;

  typedef struct packed {
    logic            frame_ok;
    logic            frame_fail;
    logic            checksum_match;
    logic [7:0]      frame_uid;
    logic [7:0]      sender_id;
    logic [3:0]      resolution_bits;
    logic [8:0]      channels_in_frame;
    logic            sender_error;
    logic            mesh_active;
    logic [3:0]      hop_count;
    logic [7:0]      error_total;
    logic [ValW-1:0] channel_value;
  } out_t;

  // outcome of unpacking one data byte
  typedef struct packed {
    logic            wr0_en;
    logic [ValW-1:0] wr0_data;
    logic            wr1_en;
    logic [ValW-1:0] wr1_data;
    logic [ValW-1:0] partial;
    logic [3:0]      bitpos;
    logic [CntW-1:0] widx;
  } unp_t;

endpackage

// ===== rtl/core/rcfr_unpack.sv =====
`timescale 1ns / 1ps

module rcfr_unpack import rcfr_pkg::*; (
  input  logic [7:0]      byte_i,
  input  logic [3:0]      res_bits_i,
  input  logic [CntW-1:0] chan_count_i,
  input  logic [ValW-1:0] partial_i,
  input  logic [3:0]      bitpos_i,
  input  logic [CntW-1:0] widx_i,
  output unp_t            unp_o
);

  logic [ValW:0]     mask_wide;
  logic [ValW-1:0]   mask;
  logic [ValW+7:0]   shifted;
  logic [ValW-1:0]   field0;
  logic [3:0]        need;
  logic [3:0]        rem_bits;
  logic [7:0]        rem;
  logic [7:0]        rem2;
  logic [CntW-1:0]   widx1;
  logic [CntW-1:0]   widx2;

  always_comb begin
    mask_wide = ({{ValW{1'b0}}, 1'b1} << res_bits_i) - {{ValW{1'b0}}, 1'b1};
    mask      = mask_wide[ValW-1:0];
    shifted   = {{ValW{1'b0}}, byte_i} << bitpos_i;
    field0    = partial_i | (shifted[ValW-1:0] & mask);
    need      = res_bits_i - bitpos_i;
    rem_bits  = 4'd8 - need;
    rem       = byte_i >> need;
    rem2      = rem >> res_bits_i;
    widx1     = widx_i + CntW'(1);
    widx2     = widx_i + CntW'(2);

    unp_o          = '0;
    unp_o.wr0_data = field0;
    unp_o.wr1_data = {{(ValW-8){1'b0}}, rem} & mask;
    unp_o.partial  = partial_i;
    unp_o.bitpos   = bitpos_i;
    unp_o.widx     = widx_i;

    if (widx_i < chan_count_i) begin
      if (need > 4'd8) begin
        // byte lands entirely inside the current value
        unp_o.partial = field0;
        unp_o.bitpos  = bitpos_i + 4'd8;
      end else begin
        unp_o.wr0_en = 1'b1;
        unp_o.widx   = widx1;
        if (widx1 >= chan_count_i) begin
          unp_o.partial = '0;
          unp_o.bitpos  = '0;
        end else if (rem_bits >= res_bits_i) begin
          // short resolution: a second value completes in the same byte
          unp_o.wr1_en = 1'b1;
          unp_o.widx   = widx2;
          if (widx2 >= chan_count_i) begin
            unp_o.partial = '0;
            unp_o.bitpos  = '0;
          end else begin
            unp_o.partial = {{(ValW-8){1'b0}}, rem2};
            unp_o.bitpos  = rem_bits - res_bits_i;
          end
        end else begin
          unp_o.partial = {{(ValW-8){1'b0}}, rem};
          unp_o.bitpos  = rem_bits;
        end
      end
    end
  end

endmodule

// ===== rtl/core/rc_frame_receiver_top.sv =====
`timescale 1ns / 1ps
// a result passes through the stage-1 register, which holds the channel memory read,
// and then through the output register
// throughput: one transaction per cycle while the output is not stalled; a data byte that
// completes two channel values holds ready low as the single memory port writes the second
// reset: control and frame state clear at once; the channel memory is not cleared,
// entries not yet reached in the current frame read as 0 through the write index

module rc_frame_receiver_top import rcfr_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_data_o
);

  localparam logic [2:0] PhIdle   = 3'd0;
  localparam logic [2:0] PhUid    = 3'd1;
  localparam logic [2:0] PhSender = 3'd2;
  localparam logic [2:0] PhConfig = 3'd3;
  localparam logic [2:0] PhMesh   = 3'd4;
  localparam logic [2:0] PhData   = 3'd5;
  localparam logic [2:0] PhCheck  = 3'd6;
  localparam logic [2:0] PhEnd    = 3'd7;

  logic [2:0]      phase_q, phase_d;
  logic [7:0]      uid_q, uid_d;
  logic [7:0]      sender_q, sender_d;
  logic [2:0]      res_key_q, res_key_d;
  logic [2:0]      cnt_key_q, cnt_key_d;
  logic            serr_q, serr_d;
  logic [3:0]      hop_q, hop_d;
  logic [CntW-1:0] byte_cnt_q, byte_cnt_d;
  logic [7:0]      xor_q, xor_d;
  logic            chk_q, chk_d;
  logic [7:0]      err_q, err_d;
  logic [ValW-1:0] partial_q, partial_d;
  logic [3:0]      bitpos_q, bitpos_d;
  logic [CntW-1:0] widx_q, widx_d;

  logic            pend_q, pend_d;
  logic [IdxW-1:0] pend_addr_q, pend_addr_d;
  logic [ValW-1:0] pend_data_q, pend_data_d;

  logic            s1_valid_q;
  out_t            s1_q, s1_d;
  logic            s1_mem_q, s1_mem_d;
  logic            out_valid_q;
  out_t            out_q, out_d;

  logic [ValW-1:0] mem_q [MaxChannels];
  logic [ValW-1:0] rdata_q;
  logic            mem_we;
  logic [IdxW-1:0] mem_waddr;
  logic [ValW-1:0] mem_wdata;
  logic            mem_re;

  logic            accept;
  logic            byte_go;
  logic            s1_move;
  logic [3:0]      res_bits;
  logic [CntW-1:0] chan_count;
  logic [2:0]      cnt_shift;
  logic [11:0]     total_bits;
  logic [12:0]     total_round;
  logic [9:0]      frame_size;
  logic [9:0]      byte_cnt_inc;
  logic [CntW-1:0] idx_ext;
  logic [7:0]      err_bumped;
  logic            ok, fail;
  unp_t            unp;

  assign res_bits     = 4'd5 + {1'b0, res_key_q};
  assign cnt_shift    = (cnt_key_q == 3'd7) ? 3'd0 : cnt_key_q;
  assign chan_count   = (cnt_key_q == 3'd7) ? CntW'(MaxChannels)
                                            : (CntW'(1) << cnt_shift);
  assign total_bits   = (cnt_key_q == 3'd7) ? {res_bits, 8'd0}
                                            : ({8'd0, res_bits} << cnt_key_q);
  assign total_round  = {1'b0, total_bits} + 13'd7;
  assign frame_size   = total_round[12:3];
  assign byte_cnt_inc = {1'b0, byte_cnt_q} + 10'd1;
  assign err_bumped   = (err_q == 8'hFF) ? err_q : err_q + 8'd1;
  assign idx_ext      = {1'b0, in_data_i.channel_index};

  assign s1_move    = s1_valid_q & (~out_valid_q | out_ready_i);
  assign in_ready_o = ~pend_q & (~s1_valid_q | s1_move);
  assign accept     = in_valid_i & in_ready_o;
  assign byte_go    = accept & (in_data_i.opcode == OpRxByte);

  rcfr_unpack u_unpack (
    .byte_i       (in_data_i.data_byte),
    .res_bits_i   (res_bits),
    .chan_count_i (chan_count),
    .partial_i    (partial_q),
    .bitpos_i     (bitpos_q),
    .widx_i       (widx_q),
    .unp_o        (unp)
  );

  always_comb begin
    phase_d     = phase_q;
    uid_d       = uid_q;
    sender_d    = sender_q;
    res_key_d   = res_key_q;
    cnt_key_d   = cnt_key_q;
    serr_d      = serr_q;
    hop_d       = hop_q;
    byte_cnt_d  = byte_cnt_q;
    xor_d       = xor_q;
    chk_d       = chk_q;
    err_d       = err_q;
    partial_d   = partial_q;
    bitpos_d    = bitpos_q;
    widx_d      = widx_q;
    pend_d      = 1'b0;
    pend_addr_d = pend_addr_q;
    pend_data_d = pend_data_q;
    ok          = 1'b0;
    fail        = 1'b0;
    mem_we      = pend_q;
    mem_waddr   = pend_addr_q;
    mem_wdata   = pend_data_q;

    if (byte_go) begin
      case (phase_q)
        PhIdle: begin
          if (in_data_i.data_byte == StartMark) phase_d = PhUid;
        end
        PhUid: begin
          uid_d   = in_data_i.data_byte;
          xor_d   = in_data_i.data_byte;
          phase_d = PhSender;
        end
        PhSender: begin
          sender_d = in_data_i.data_byte;
          xor_d    = xor_q ^ in_data_i.data_byte;
          phase_d  = PhConfig;
        end
        PhConfig: begin
          xor_d      = xor_q ^ in_data_i.data_byte;
          res_key_d  = in_data_i.data_byte[2:0];
          cnt_key_d  = in_data_i.data_byte[5:3];
          serr_d     = in_data_i.data_byte[6];
          byte_cnt_d = '0;
          partial_d  = '0;
          bitpos_d   = '0;
          widx_d     = '0;
          phase_d    = in_data_i.data_byte[7] ? PhMesh : PhData;
        end
        PhMesh: begin
          xor_d   = xor_q ^ in_data_i.data_byte;
          hop_d   = in_data_i.data_byte[3:0];
          phase_d = PhData;
        end
        PhData: begin
          xor_d       = xor_q ^ in_data_i.data_byte;
          partial_d   = unp.partial;
          bitpos_d    = unp.bitpos;
          widx_d      = unp.widx;
          byte_cnt_d  = byte_cnt_inc[CntW-1:0];
          mem_we      = unp.wr0_en;
          mem_waddr   = widx_q[IdxW-1:0];
          mem_wdata   = unp.wr0_data;
          pend_d      = unp.wr1_en;
          pend_addr_d = widx_q[IdxW-1:0] + IdxW'(1);
          pend_data_d = unp.wr1_data;
          if (byte_cnt_inc >= frame_size) phase_d = PhCheck;
        end
        PhCheck: begin
          chk_d   = (in_data_i.data_byte == xor_q);
          if (in_data_i.data_byte != xor_q) err_d = err_bumped;
          phase_d = PhEnd;
        end
        default: begin
          if (in_data_i.data_byte == EndMark) begin
            ok = 1'b1;
          end else begin
            fail  = 1'b1;
            err_d = err_bumped;
          end
          phase_d = PhIdle;
        end
      endcase
    end
  end

  // stage-1 result: frame status plus the channel read: finished values from memory, the one
  // in progress from the partial register; anything not reached yet in this frame or out of range reads 0
  always_comb begin
    s1_d                   = '0;
    s1_mem_d               = 1'b0;
    s1_d.frame_ok          = ok;
    s1_d.frame_fail        = fail;
    s1_d.checksum_match    = chk_d;
    s1_d.frame_uid         = uid_d;
    s1_d.sender_id         = sender_d;
    s1_d.resolution_bits   = 4'd5 + {1'b0, res_key_d};
    s1_d.channels_in_frame = (cnt_key_d == 3'd7) ? CntW'(MaxChannels)
                                                 : (CntW'(1) << cnt_key_d);
    s1_d.sender_error      = serr_d;
    s1_d.mesh_active       = (hop_d != 4'd0);
    s1_d.hop_count         = hop_d;
    s1_d.error_total       = err_d;
    if (in_data_i.opcode == OpReadChan && idx_ext < chan_count) begin
      if (idx_ext < widx_q) begin
        s1_mem_d = 1'b1;
      end else if (idx_ext == widx_q) begin
        s1_d.channel_value = partial_q;
      end
    end
  end

  always_comb begin
    out_d = s1_q;
    if (s1_mem_q) out_d.channel_value = rdata_q;
  end

  assign mem_re = accept & (in_data_i.opcode == OpReadChan);

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_waddr] <= mem_wdata;
  end

  always_ff @(posedge clk_i) begin
    if (mem_re) rdata_q <= mem_q[in_data_i.channel_index];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhIdle;
      uid_q       <= '0;
      sender_q    <= '0;
      res_key_q   <= '0;
      cnt_key_q   <= '0;
      serr_q      <= 1'b0;
      hop_q       <= '0;
      byte_cnt_q  <= '0;
      xor_q       <= '0;
      chk_q       <= 1'b0;
      err_q       <= '0;
      partial_q   <= '0;
      bitpos_q    <= '0;
      widx_q      <= '0;
      pend_q      <= 1'b0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q    <= phase_d;
      uid_q      <= uid_d;
      sender_q   <= sender_d;
      res_key_q  <= res_key_d;
      cnt_key_q  <= cnt_key_d;
      serr_q     <= serr_d;
      hop_q      <= hop_d;
      byte_cnt_q <= byte_cnt_d;
      xor_q      <= xor_d;
      chk_q      <= chk_d;
      err_q      <= err_d;
      partial_q  <= partial_d;
      bitpos_q   <= bitpos_d;
      widx_q     <= widx_d;
      pend_q     <= pend_d;
      if (accept) begin
        s1_valid_q <= 1'b1;
      end else if (s1_move) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_move) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pend_addr_q <= pend_addr_d;
    pend_data_q <= pend_data_d;
    if (accept) begin
      s1_q     <= s1_d;
      s1_mem_q <= s1_mem_d;
    end
    if (s1_move) out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== test/rcfr_checker.sv =====
`timescale 1ns / 1ps

module rcfr_checker import rcfr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  in_t         in_data_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  out_t        out_data_i,
  output int unsigned pending_o,
  output int unsigned fail_count_o
);

  typedef enum logic [2:0] {
    WaitStart, GetUid, GetSender, GetConfig, GetMesh, GetData, GetCheck, GetEnd
  } rx_phase_e;

  rx_phase_e       phase_q;
  logic [7:0]      uid_q;
  logic [7:0]      sender_q;
  logic [2:0]      res_key_q;
  logic [2:0]      count_key_q;
  logic            sender_err_q;
  logic [3:0]      hop_q;
  int unsigned     data_cnt_q;
  logic [7:0]      xor_q;
  logic            sum_ok_q;
  logic [7:0]      err_cnt_q;
  logic [ValW-1:0] partial_q;
  int unsigned     bit_pos_q;
  int unsigned     wr_idx_q;
  logic [ValW-1:0] chan_mem [MaxChannels];

  out_t expected_q[$];
  out_t want;

  function automatic int unsigned chan_bits();
    return 5 + int'(res_key_q);
  endfunction

  function automatic int unsigned chan_count();
    return (count_key_q == 3'd7) ? 256 : (1 << count_key_q);
  endfunction

  function automatic void clear_model();
    phase_q      = WaitStart;
    uid_q        = '0;
    sender_q     = '0;
    res_key_q    = '0;
    count_key_q  = '0;
    sender_err_q = 1'b0;
    hop_q        = '0;
    data_cnt_q   = 0;
    xor_q        = '0;
    sum_ok_q     = 1'b0;
    err_cnt_q    = '0;
    partial_q    = '0;
    bit_pos_q    = 0;
    wr_idx_q     = 0;
    for (int c = 0; c < MaxChannels; c++) chan_mem[c] = '0;
  endfunction

  function automatic void bump_errors();
    if (err_cnt_q != 8'hFF) err_cnt_q++;
  endfunction

  // lsb first; bits past the last channel fall away
  function automatic void place_bit(logic bit_v);
    if (wr_idx_q >= chan_count()) return;
    partial_q = partial_q | (ValW'(bit_v) << bit_pos_q);
    chan_mem[wr_idx_q] = partial_q;
    bit_pos_q++;
    if (bit_pos_q >= chan_bits()) begin
      bit_pos_q = 0;
      partial_q = '0;
      wr_idx_q++;
    end
  endfunction

  function automatic out_t predict_result(in_t txn);
    out_t        res;
    logic [7:0]  b;
    int unsigned need;
    res = '0;
    b   = txn.data_byte;
    if (txn.opcode == OpRxByte) begin
      case (phase_q)
        WaitStart: begin
          if (b == StartMark) phase_q = GetUid;
        end
        GetUid: begin
          uid_q   = b;
          xor_q   = b;
          phase_q = GetSender;
        end
        GetSender: begin
          sender_q = b;
          xor_q    = xor_q ^ b;
          phase_q  = GetConfig;
        end
        GetConfig: begin
          xor_q        = xor_q ^ b;
          res_key_q    = b[2:0];
          count_key_q  = b[5:3];
          sender_err_q = b[6];
          for (int c = 0; c < chan_count(); c++) chan_mem[c] = '0;
          data_cnt_q = 0;
          partial_q  = '0;
          bit_pos_q  = 0;
          wr_idx_q   = 0;
          phase_q    = b[7] ? GetMesh : GetData;
        end
        GetMesh: begin
          xor_q   = xor_q ^ b;
          hop_q   = b[3:0];
          phase_q = GetData;
        end
        GetData: begin
          xor_q = xor_q ^ b;
          for (int k = 0; k < 8; k++) place_bit(b[k]);
          data_cnt_q++;
          need = (chan_bits() * chan_count() + 7) / 8;
          if (data_cnt_q >= need) phase_q = GetCheck;
        end
        GetCheck: begin
          sum_ok_q = (b == xor_q);
          if (!sum_ok_q) bump_errors();
          phase_q = GetEnd;
        end
        default: begin
          if (b == EndMark) begin
            res.frame_ok = 1'b1;
          end else begin
            res.frame_fail = 1'b1;
            bump_errors();
          end
          phase_q = WaitStart;
        end
      endcase
    end else if (txn.channel_index < chan_count()) begin
      res.channel_value = chan_mem[txn.channel_index];
    end
    res.checksum_match    = sum_ok_q;
    res.frame_uid         = uid_q;
    res.sender_id         = sender_q;
    res.resolution_bits   = 4'(chan_bits());
    res.channels_in_frame = 9'(chan_count());
    res.sender_error      = sender_err_q;
    res.mesh_active       = (hop_q != 4'd0);
    res.hop_count         = hop_q;
    res.error_total       = err_cnt_q;
    return res;
  endfunction

  task automatic check_field(input string name, input logic [11:0] exp_v, got_v);
    if (got_v !== exp_v) begin
      $display("%0t rcfr_checker: %s expected 0x%0h, got 0x%0h", $time, name, exp_v, got_v);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_model();
      expected_q.delete();
      pending_o    = 0;
      fail_count_o = 0;
    end else begin
      if (in_valid_i && in_ready_i) expected_q.push_back(predict_result(in_data_i));
      if (out_valid_i && out_ready_i) begin
        if (expected_q.size() == 0) begin
          $display("%0t rcfr_checker: result with nothing expected, got 0x%0h", $time,
                   out_data_i);
          fail_count_o++;
        end else begin
          want = expected_q.pop_front();
          check_field("frame_ok", want.frame_ok, out_data_i.frame_ok);
          check_field("frame_fail", want.frame_fail, out_data_i.frame_fail);
          check_field("checksum_match", want.checksum_match, out_data_i.checksum_match);
          check_field("frame_uid", want.frame_uid, out_data_i.frame_uid);
          check_field("sender_id", want.sender_id, out_data_i.sender_id);
          check_field("resolution_bits", want.resolution_bits, out_data_i.resolution_bits);
          check_field("channels_in_frame", want.channels_in_frame,
                      out_data_i.channels_in_frame);
          check_field("sender_error", want.sender_error, out_data_i.sender_error);
          check_field("mesh_active", want.mesh_active, out_data_i.mesh_active);
          check_field("hop_count", want.hop_count, out_data_i.hop_count);
          check_field("error_total", want.error_total, out_data_i.error_total);
          check_field("channel_value", want.channel_value, out_data_i.channel_value);
        end
      end
      pending_o = expected_q.size();
    end
  end

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import rcfr_pkg::*;

  localparam int unsigned CycleLimit = 200000;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_t  in_data;
  logic out_valid;
  logic out_ready;
  out_t out_data;

  int unsigned pending;
  int unsigned fail_count;
  int unsigned items_sent;
  int unsigned cycle_count;
  int unsigned idle_pct;
  int unsigned stall_pct;
  int unsigned cur_count;
  int unsigned hold_left;
  bit          hold_req;

  rc_frame_receiver_top dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  rcfr_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_data_i   (out_data),
    .pending_o    (pending),
    .fail_count_o (fail_count)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CycleLimit) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  // result side: random stalls plus one long hold-off on request
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = 400;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  task automatic drive(input in_t txn);
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= txn;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic put_byte(input logic [7:0] b);
    in_t txn;
    txn.opcode        = OpRxByte;
    txn.data_byte     = b;
    txn.channel_index = 8'($urandom);
    drive(txn);
  endtask

  task automatic put_read(input logic [7:0] idx);
    in_t txn;
    txn.opcode        = OpReadChan;
    txn.data_byte     = 8'($urandom);
    txn.channel_index = idx;
    drive(txn);
  endtask

  // reads lean toward channels of the current frame, so partial values show up
  task automatic maybe_read(input int unsigned pct);
    if ($urandom_range(99) < pct) begin
      if ($urandom_range(9) < 7) put_read(8'($urandom_range(cur_count - 1)));
      else put_read(8'($urandom));
    end
  endtask

  // fill < 0 gives random data bytes
  task automatic send_frame(input logic [7:0] uid, sid, cfg, mesh_byte, input int fill,
                            input bit sum_good, end_good, input int unsigned read_pct);
    logic [7:0]  sum;
    logic [7:0]  b;
    int unsigned nbytes;
    put_byte(StartMark);
    maybe_read(read_pct);
    put_byte(uid);
    maybe_read(read_pct);
    put_byte(sid);
    maybe_read(read_pct);
    put_byte(cfg);
    sum       = uid ^ sid ^ cfg;
    cur_count = (cfg[5:3] == 3'd7) ? 256 : (1 << cfg[5:3]);
    nbytes    = ((5 + int'(cfg[2:0])) * cur_count + 7) / 8;
    maybe_read(read_pct);
    if (cfg[7]) begin
      put_byte(mesh_byte);
      sum = sum ^ mesh_byte;
      maybe_read(read_pct);
    end
    repeat (nbytes) begin
      b = (fill < 0) ? 8'($urandom) : 8'(fill);
      put_byte(b);
      sum = sum ^ b;
      maybe_read(read_pct);
    end
    put_byte(sum_good ? sum : sum ^ 8'($urandom_range(255, 1)));
    maybe_read(read_pct);
    b = 8'($urandom);
    if (b == EndMark) b = ~b;
    put_byte(end_good ? EndMark : b);
    maybe_read(read_pct);
  endtask

  // storm frames hold one channel in one data byte and carry both a bad checksum and a bad end
  task automatic random_frame(input bit storm);
    logic [7:0]  junk;
    logic [2:0]  ck;
    logic [2:0]  rk;
    int unsigned r;
    r = $urandom_range(99);
    if (storm) ck = 3'd0;
    else if (r < 1) ck = 3'd7;
    else if (r < 4) ck = 3'd6;
    else if (r < 10) ck = 3'd5;
    else ck = 3'($urandom_range(4));
    rk = storm ? 3'($urandom_range(3)) : 3'($urandom_range(7));
    if ($urandom_range(9) == 0) begin
      repeat ($urandom_range(3, 1)) begin
        junk = 8'($urandom);
        if (junk == StartMark) junk = 8'h00;
        put_byte(junk);
      end
    end
    send_frame(8'($urandom), 8'($urandom), {2'($urandom), ck, rk}, 8'($urandom), -1,
               !storm && ($urandom_range(99) < 85), !storm && ($urandom_range(99) < 85),
               storm ? 3 : 8);
  endtask

  initial begin
    int unsigned target;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    idle_pct  = 0;
    stall_pct = 0;
    cur_count = 1;
    hold_req  = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // before any config only one channel exists, so a high index reads zero
    put_read(8'hFF);
    put_byte(8'h00);
    put_byte(8'hFF);
    // mesh with full hop count, error bit, widest value, one channel, padding nibble
    send_frame(8'hFF, 8'h00, 8'hC7, 8'hFF, 8'hFF, 1'b1, 1'b1, 0);
    put_read(8'h00);
    put_read(8'h01);
    // no mesh byte keeps the old hop count; bad checksum and bad end byte
    send_frame(8'h00, 8'hFF, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 0);
    put_read(8'h00);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          idle_pct  = 0;
          stall_pct = 0;
          hold_req  = 1'b1;
        end
        1: begin
          idle_pct  = 63;
          stall_pct = 0;
        end
        2: begin
          idle_pct  = 0;
          stall_pct = 63;
        end
        default: begin
          idle_pct  = 12;
          stall_pct = 12;
        end
      endcase
      target = items_sent + 200;
      // one full-size frame: all 256 channels at 12 bits
      if (ph == 2) send_frame(8'($urandom), 8'($urandom), {2'($urandom), 6'h3F},
                              8'($urandom), -1, 1'b1, 1'b1, 8);
      while (items_sent < target) random_frame(1'b0);
    end
    // enough errors to drive the counter into saturation
    repeat (130) random_frame(1'b1);

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (fail_count == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/rcfr_pkg.sv
rtl/core/rcfr_unpack.sv
rtl/core/rc_frame_receiver_top.sv
test/rcfr_checker.sv
test/tb.sv
